// File: rtl/bpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

  // Width of a symbol count and of the mismatch threshold (0 to 31).
  localparam int LEN_W = 5;

  // Item commands.
  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_LOADED  = 2'd0;
  localparam logic [1:0] STATUS_MATCHED = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd2;
  localparam logic [1:0] STATUS_FULL    = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } bpc_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic do_load;
    logic scan_begin;
    logic miss_empty;
    logic scan_next;
    logic scan_hit;
    logic scan_miss;
  } bpc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic table_empty;
    logic entry_match;
    logic cur_zero;
  } bpc_stat_t;

endpackage

`default_nettype wire

// File: rtl/bpc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                           wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/bpc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bpc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              item_cmd_i,
  input  wire bpc_pkg::bpc_stat_t stat_i,
  output bpc_pkg::bpc_cmd_t      ctrl_o,
  output logic                   busy_o
);

  bpc_pkg::bpc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bpc_pkg::ST_IDLE: begin
        if (start_i && item_cmd_i == bpc_pkg::CMD_CLASSIFY && !stat_i.table_empty) begin
          state_d = bpc_pkg::ST_SCAN;
        end
      end
      bpc_pkg::ST_SCAN: begin
        if (stat_i.entry_match || stat_i.cur_zero) begin
          state_d = bpc_pkg::ST_IDLE;
        end
      end
      default: state_d = bpc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    busy_o = 1'b0;
    unique case (state_q)
      bpc_pkg::ST_IDLE: begin
        if (start_i) begin
          if (item_cmd_i == bpc_pkg::CMD_LOAD) begin
            ctrl_o.do_load = 1'b1;
          end else if (stat_i.table_empty) begin
            ctrl_o.miss_empty = 1'b1;
          end else begin
            ctrl_o.scan_begin = 1'b1;
          end
        end
      end
      bpc_pkg::ST_SCAN: begin
        busy_o = 1'b1;
        // newest entry first; stop at the first hit or after slot 0
        if (stat_i.entry_match) begin
          ctrl_o.scan_hit = 1'b1;
        end else if (stat_i.cur_zero) begin
          ctrl_o.scan_miss = 1'b1;
        end else begin
          ctrl_o.scan_next = 1'b1;
        end
      end
      default: busy_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/bpc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module bpc_datapath #(
  parameter int MAX_ENTRIES = 16,
  parameter int MAX_SYMBOLS = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [63:0]                 symbols_i,
  input  wire logic [bpc_pkg::LEN_W-1:0]   symbol_count_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [bpc_pkg::LEN_W-1:0]   cfg_data_i,
  input  wire bpc_pkg::bpc_cmd_t           ctrl_i,
  output bpc_pkg::bpc_stat_t               stat_o,
  output logic                             done_o,
  output logic [1:0]                       status_o,
  output logic [3:0]                       match_index_o,
  output logic [bpc_pkg::LEN_W-1:0]        trim_length_o,
  output logic [31:0]                      barcode_count_o,
  output logic [31:0]                      total_count_o,
  output logic [31:0]                      unknown_count_o
);

  localparam int LW = bpc_pkg::LEN_W;
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int FW = $clog2(MAX_ENTRIES + 1);
  localparam int SW = 4 * MAX_SYMBOLS;
  localparam int EW = SW + LW;

  logic [FW-1:0]          fill_q, fill_d;
  logic [IW-1:0]          cur_q, cur_d;
  logic [SW-1:0]          rsym_q;
  logic [LW-1:0]          rlen_q;
  logic [LW-1:0]          mm_q;
  logic [COUNT_WIDTH-1:0] seen_q, seen_d;
  logic [COUNT_WIDTH-1:0] unm_q, unm_d;

  logic                   full;
  logic [IW-1:0]          fill_idx;
  logic [IW-1:0]          fill_last;
  logic [IW-1:0]          cur_prev;
  logic [LW-1:0]          len_clamp;
  logic                   load_ok;

  logic                   ent_we;
  logic [EW-1:0]          ent_rdata;
  logic [IW-1:0]          rd_addr;
  logic                   hits_we;
  logic [IW-1:0]          hits_waddr;
  logic [COUNT_WIDTH-1:0] hits_wdata;
  logic [COUNT_WIDTH-1:0] hits_rdata;
  logic [COUNT_WIDTH-1:0] hit_inc;

  logic [LW-1:0]          elen;
  logic [SW-1:0]          esym;
  logic [MAX_SYMBOLS-1:0] diff;
  logic [LW-1:0]          miss_cnt;

  logic                   done_d;
  logic [1:0]             res_status_d;
  logic [3:0]             res_index_d;
  logic [LW-1:0]          res_trim_d;
  logic [31:0]            res_hits_d;

  assign full      = (fill_q == FW'(MAX_ENTRIES));
  assign fill_idx  = fill_q[IW-1:0];
  assign fill_last = fill_idx - IW'(1);
  assign cur_prev  = cur_q - IW'(1);
  assign len_clamp = (symbol_count_i > LW'(MAX_SYMBOLS)) ? LW'(MAX_SYMBOLS) : symbol_count_i;
  assign load_ok   = ctrl_i.do_load && !full;

  // Entry table: barcode length above its symbols.
  assign ent_we  = load_ok;
  assign rd_addr = ctrl_i.scan_begin ? fill_last : cur_prev;

  bpc_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (fill_idx),
    .wdata_i ({len_clamp, symbols_i[SW-1:0]}),
    .raddr_i (rd_addr),
    .rdata_o (ent_rdata)
  );

  // Hit counters: cleared by the load that fills a slot, bumped on a hit.
  assign hit_inc    = (hits_rdata == '1) ? hits_rdata : hits_rdata + COUNT_WIDTH'(1);
  assign hits_we    = load_ok || ctrl_i.scan_hit;
  assign hits_waddr = ctrl_i.scan_hit ? cur_q : fill_idx;
  assign hits_wdata = ctrl_i.scan_hit ? hit_inc : '0;

  bpc_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (MAX_ENTRIES)
  ) u_hits_ram (
    .clk_i   (clk_i),
    .we_i    (hits_we),
    .waddr_i (hits_waddr),
    .wdata_i (hits_wdata),
    .raddr_i (rd_addr),
    .rdata_o (hits_rdata)
  );

  // Compare the entry read last cycle against the held read.
  assign elen = ent_rdata[EW-1:SW];
  assign esym = ent_rdata[SW-1:0];

  always_comb begin
    for (int p = 0; p < MAX_SYMBOLS; p++) begin
      diff[p] = (LW'(p) < elen) &&
                ((LW'(p) >= rlen_q) || (esym[4*p +: 4] != rsym_q[4*p +: 4]));
    end
  end

  assign miss_cnt = LW'($countones(diff));

  assign stat_o.table_empty = (fill_q == '0);
  assign stat_o.entry_match = (miss_cnt <= mm_q);
  assign stat_o.cur_zero    = (cur_q == '0);

  always_comb begin
    fill_d = fill_q;
    cur_d  = cur_q;
    seen_d = seen_q;
    unm_d  = unm_q;
    if (load_ok) begin
      fill_d = fill_q + FW'(1);
    end
    if (ctrl_i.scan_begin) begin
      cur_d = fill_last;
    end else if (ctrl_i.scan_next) begin
      cur_d = cur_prev;
    end
    if (ctrl_i.miss_empty || ctrl_i.scan_miss || ctrl_i.scan_hit) begin
      seen_d = (seen_q == '1) ? seen_q : seen_q + COUNT_WIDTH'(1);
    end
    if (ctrl_i.miss_empty || ctrl_i.scan_miss) begin
      unm_d = (unm_q == '1) ? unm_q : unm_q + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      cur_q  <= '0;
      seen_q <= '0;
      unm_q  <= '0;
      mm_q   <= '0;
      done_o <= 1'b0;
    end else begin
      fill_q <= fill_d;
      cur_q  <= cur_d;
      seen_q <= seen_d;
      unm_q  <= unm_d;
      done_o <= done_d;
      if (cfg_we_i) begin
        mm_q <= cfg_data_i;
      end
    end
  end

  // Hold the read for the whole scan.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.scan_begin) begin
      rsym_q <= symbols_i[SW-1:0];
      rlen_q <= len_clamp;
    end
  end

  always_comb begin
    done_d       = ctrl_i.do_load || ctrl_i.miss_empty || ctrl_i.scan_hit || ctrl_i.scan_miss;
    res_status_d = bpc_pkg::STATUS_UNKNOWN;
    res_index_d  = '0;
    res_trim_d   = '0;
    res_hits_d   = '0;
    if (ctrl_i.do_load) begin
      if (full) begin
        res_status_d = bpc_pkg::STATUS_FULL;
      end else begin
        res_status_d = bpc_pkg::STATUS_LOADED;
        res_index_d  = 4'(fill_idx);
        res_trim_d   = len_clamp;
      end
    end else if (ctrl_i.scan_hit) begin
      res_status_d = bpc_pkg::STATUS_MATCHED;
      res_index_d  = 4'(cur_q);
      res_trim_d   = elen;
      res_hits_d   = 32'(hit_inc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_d) begin
      status_o        <= res_status_d;
      match_index_o   <= res_index_d;
      trim_length_o   <= res_trim_d;
      barcode_count_o <= res_hits_d;
      total_count_o   <= 32'(seen_d);
      unknown_count_o <= 32'(unm_d);
    end
  end

endmodule

`default_nettype wire

// File: rtl/barcode_prefix_classifier_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Barcode prefix classifier.
// Items: drive cmd_i, symbols_i and symbol_count_i with start high; the item
// is taken at a clock edge where start is high and busy is low. A load
// (cmd_i = 0) appends a barcode to the table, or reports full once the
// table is full; a classify (cmd_i = 1) searches the table from the newest
// entry down to slot 0 for the first entry within the mismatch threshold.
// Results: one beat per item, valid for exactly one cycle while done_o is
// high; the receiver must take it then, there is no back-pressure.
// Flow: a load, or a classify on an empty table, gives its beat in the
// cycle after it is taken and busy stays low. A classify on a filled table
// holds busy while it examines entries (1 up to the fill count), and gives
// its beat in the cycle in which busy drops. The table RAM is read one entry
// per cycle.
// Configuration: max_mismatches is written on cfg_data_i when cfg_valid_i
// and cfg_ready_o are both high; cfg_ready_o is low while a scan runs.
// Reset: table empty, all counters zero, threshold zero. The RAMs are not
// cleared; only slots already loaded are ever read.
module barcode_prefix_classifier_unit #(
  parameter int MAX_ENTRIES = 16,
  parameter int MAX_SYMBOLS = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      cmd_i,
  input  wire logic [63:0]               symbols_i,
  input  wire logic [bpc_pkg::LEN_W-1:0] symbol_count_i,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [bpc_pkg::LEN_W-1:0] cfg_data_i,
  output logic                           done_o,
  output logic [1:0]                     status_o,
  output logic [3:0]                     match_index_o,
  output logic [bpc_pkg::LEN_W-1:0]      trim_length_o,
  output logic [31:0]                    barcode_count_o,
  output logic [31:0]                    total_count_o,
  output logic [31:0]                    unknown_count_o
);

  bpc_pkg::bpc_cmd_t  ctrl;
  bpc_pkg::bpc_stat_t stat;
  logic               busy_w;
  logic               cfg_we;

  assign busy        = busy_w;
  assign cfg_ready_o = !busy_w;
  assign cfg_we      = cfg_valid_i && !busy_w;

  bpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .item_cmd_i (cmd_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .busy_o     (busy_w)
  );

  bpc_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .symbols_i       (symbols_i),
    .symbol_count_i  (symbol_count_i),
    .cfg_we_i        (cfg_we),
    .cfg_data_i      (cfg_data_i),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .done_o          (done_o),
    .status_o        (status_o),
    .match_index_o   (match_index_o),
    .trim_length_o   (trim_length_o),
    .barcode_count_o (barcode_count_o),
    .total_count_o   (total_count_o),
    .unknown_count_o (unknown_count_o)
  );

  // A beat never comes while a scan runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_w)
    else $error("result beat while scan still running");

  // Every taken item either scans or delivers on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy_w) |=> (done_o || busy_w))
    else $error("taken item neither scanning nor delivered");

  // Unknown and full results carry no slot, length or hit count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == bpc_pkg::STATUS_UNKNOWN || status_o == bpc_pkg::STATUS_FULL))
    |-> (match_index_o == '0 && trim_length_o == '0 && barcode_count_o == '0))
    else $error("no-slot result carries slot data");

  // The scan ends on the cycle a match is seen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_w && stat.entry_match) |=> (done_o && status_o == bpc_pkg::STATUS_MATCHED))
    else $error("match seen but not reported");

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int LEN_W       = bpc_pkg::LEN_W;
  localparam int TABLE_SLOTS = 16;
  localparam int MAX_LEN     = 16;
  localparam int IDLE_LIMIT  = 3000;

  typedef struct packed {
    logic [1:0]       status;
    logic [3:0]       index;
    logic [LEN_W-1:0] trim;
    logic [31:0]      hits;
    logic [31:0]      total;
    logic [31:0]      unknown;
  } demux_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              cmd_i;
  logic [63:0]       symbols_i;
  logic [LEN_W-1:0]  symbol_count_i;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [LEN_W-1:0]  cfg_data_i;
  logic              done_o;
  logic [1:0]        status_o;
  logic [3:0]        match_index_o;
  logic [LEN_W-1:0]  trim_length_o;
  logic [31:0]       barcode_count_o;
  logic [31:0]       total_count_o;
  logic [31:0]       unknown_count_o;

  // Shadow copy of the barcode table and counters.
  logic [63:0]       tbl_sym [TABLE_SLOTS];
  logic [LEN_W-1:0]  tbl_len [TABLE_SLOTS];
  logic [31:0]       tbl_hits[TABLE_SLOTS];
  int unsigned       tbl_fill = 0;
  logic [31:0]       reads_total = '0;
  logic [31:0]       reads_unknown = '0;
  logic [LEN_W-1:0]  mismatch_limit = '0;

  demux_result_t     awaited_results[$];
  int unsigned       burst_left = 0;
  int unsigned       idle_cycles = 0;
  int unsigned       errors = 0;

  barcode_prefix_classifier_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .symbols_i      (symbols_i),
    .symbol_count_i (symbol_count_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .match_index_o  (match_index_o),
    .trim_length_o  (trim_length_o),
    .barcode_count_o(barcode_count_o),
    .total_count_o  (total_count_o),
    .unknown_count_o(unknown_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic demux_result_t predict_barcode_result(input logic cmd,
                                                           input logic [63:0] sym,
                                                           input logic [LEN_W-1:0] cnt);
    demux_result_t r;
    int unsigned   len;
    int unsigned   miss;
    int unsigned   p;
    int            slot;
    bit            hit;
    r = '0;
    len = (cnt > MAX_LEN) ? MAX_LEN : cnt;
    if (cmd == bpc_pkg::CMD_LOAD) begin
      if (tbl_fill >= TABLE_SLOTS) begin
        r.status = bpc_pkg::STATUS_FULL;
      end else begin
        tbl_sym[tbl_fill]  = sym;
        tbl_len[tbl_fill]  = LEN_W'(len);
        tbl_hits[tbl_fill] = '0;
        r.status = bpc_pkg::STATUS_LOADED;
        r.index  = 4'(tbl_fill);
        r.trim   = LEN_W'(len);
        tbl_fill++;
      end
    end else begin
      hit  = 1'b0;
      slot = tbl_fill;
      // Newest entry first; stop at the first one within the limit.
      while (slot > 0 && !hit) begin
        slot--;
        miss = 0;
        for (p = 0; p < tbl_len[slot]; p++)
          if (p >= len || tbl_sym[slot][4*p +: 4] != sym[4*p +: 4]) miss++;
        hit = (miss <= mismatch_limit);
      end
      reads_total = sat_inc(reads_total);
      if (hit) begin
        tbl_hits[slot] = sat_inc(tbl_hits[slot]);
        r.status = bpc_pkg::STATUS_MATCHED;
        r.index  = 4'(slot);
        r.trim   = tbl_len[slot];
        r.hits   = tbl_hits[slot];
      end else begin
        reads_unknown = sat_inc(reads_unknown);
        r.status = bpc_pkg::STATUS_UNKNOWN;
      end
    end
    r.total   = reads_total;
    r.unknown = reads_unknown;
    return r;
  endfunction

  function automatic logic [63:0] random_symbols();
    logic [63:0] s;
    if ($urandom_range(7) == 0) return {$urandom, $urandom};
    for (int p = 0; p < 16; p++) s[4*p +: 4] = 4'($urandom_range(4));
    return s;
  endfunction

  function automatic logic [LEN_W-1:0] random_load_length();
    return ($urandom_range(9) == 0) ? LEN_W'($urandom_range(17, 31))
                                    : LEN_W'($urandom_range(4, 16));
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    demux_result_t want;
    if (rst_ni && done_o) begin
      if (awaited_results.size() == 0) begin
        $error("result beat with no pending item");
        errors++;
      end else begin
        want = awaited_results.pop_front();
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("match_index", 32'(want.index), 32'(match_index_o));
        check_field("trim_length", 32'(want.trim), 32'(trim_length_o));
        check_field("barcode_count", want.hits, barcode_count_o);
        check_field("total_count", want.total, total_count_o);
        check_field("unknown_count", want.unknown, unknown_count_o);
      end
    end
  end

  // Abort when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** barcode_prefix_classifier_unit: FAILED **");
      $finish;
    end
  end

  task automatic send_item(input logic cmd, input logic [63:0] sym,
                           input logic [LEN_W-1:0] cnt);
    @(negedge clk_i);
    start          <= 1'b1;
    cmd_i          <= cmd;
    symbols_i      <= sym;
    symbol_count_i <= cnt;
    do @(posedge clk_i); while (busy);
    awaited_results.push_back(predict_barcode_result(cmd, sym, cnt));
    if (burst_left == 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk_i);
      burst_left = ($urandom_range(5) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_threshold(input logic [LEN_W-1:0] v);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    mismatch_limit = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_empty_table();
    send_item(bpc_pkg::CMD_CLASSIFY, '1, LEN_W'(16));
    send_item(bpc_pkg::CMD_CLASSIFY, '0, '0);
  endtask

  task automatic test_load_and_exact_match();
    send_item(bpc_pkg::CMD_LOAD, '1, LEN_W'(16));
    send_item(bpc_pkg::CMD_LOAD, 64'h0000_0000_3210_3210, LEN_W'(8));
    send_item(bpc_pkg::CMD_LOAD, '0, LEN_W'(31));
    send_item(bpc_pkg::CMD_LOAD, 64'h0000_0000_0000_4444, LEN_W'(4));
    send_item(bpc_pkg::CMD_CLASSIFY, '1, LEN_W'(16));
    send_item(bpc_pkg::CMD_CLASSIFY, 64'h4444_4444_3210_3210, LEN_W'(12));
    // Read ends one symbol short of the barcode.
    send_item(bpc_pkg::CMD_CLASSIFY, 64'h4444_4444_3210_3210, LEN_W'(7));
    send_item(bpc_pkg::CMD_CLASSIFY, '0, LEN_W'(16));
    send_item(bpc_pkg::CMD_CLASSIFY, '0, LEN_W'(31));
    send_item(bpc_pkg::CMD_CLASSIFY, 64'hFFFF_FFFF_FF0F_FFFF, LEN_W'(16));
    send_item(bpc_pkg::CMD_CLASSIFY, 64'h0000_0000_0000_4444, LEN_W'(0));
  endtask

  task automatic test_thresholds();
    set_threshold(LEN_W'(1));
    send_item(bpc_pkg::CMD_CLASSIFY, 64'hFFFF_FFFF_FF0F_FFFF, LEN_W'(16));
    send_item(bpc_pkg::CMD_CLASSIFY, 64'h4444_4444_3210_3210, LEN_W'(7));
    set_threshold(LEN_W'(16));
    send_item(bpc_pkg::CMD_CLASSIFY, {$urandom, $urandom}, LEN_W'(0));
    set_threshold(LEN_W'(31));
    send_item(bpc_pkg::CMD_CLASSIFY, {$urandom, $urandom}, LEN_W'(9));
    set_threshold('0);
  endtask

  task automatic test_random_traffic();
    int unsigned thresholds[10] = '{0, 2, 1, 4, 0, 3, 16, 1, 31, 2};
    int unsigned slot;
    int unsigned nmut;
    int unsigned pos;
    int          cnt;
    logic [63:0] sym;
    foreach (thresholds[ph]) begin
      set_threshold(LEN_W'(thresholds[ph]));
      for (int n = 0; n < ((thresholds[ph] >= 16) ? 20 : 75); n++) begin
        if (ph == 3 && n == 35) drain_results();
        if (tbl_fill < 14 && $urandom_range(29) == 0) begin
          send_item(bpc_pkg::CMD_LOAD, random_symbols(), random_load_length());
        end else if ($urandom_range(6) == 0) begin
          send_item(bpc_pkg::CMD_CLASSIFY, random_symbols(), LEN_W'($urandom_range(31)));
        end else begin
          // Take a loaded barcode, flip a few symbols, jitter the length.
          slot = $urandom_range(tbl_fill - 1);
          sym  = tbl_sym[slot];
          nmut = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 3);
          repeat (nmut) begin
            pos = $urandom_range(15);
            sym[4*pos +: 4] = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(4));
          end
          cnt = int'(tbl_len[slot]);
          if ($urandom_range(4) == 0) cnt = cnt - int'($urandom_range(1, 3));
          else cnt = cnt + int'($urandom_range(0, 4));
          if (cnt < 0) cnt = 0;
          if (cnt > 31) cnt = 31;
          send_item(bpc_pkg::CMD_CLASSIFY, sym, LEN_W'(cnt));
        end
      end
    end
  endtask

  task automatic test_table_full();
    set_threshold('0);
    while (tbl_fill < TABLE_SLOTS - 1)
      send_item(bpc_pkg::CMD_LOAD, random_symbols(), random_load_length());
    // Empty barcode in the last slot matches every read.
    send_item(bpc_pkg::CMD_LOAD, random_symbols(), '0);
    repeat (3) send_item(bpc_pkg::CMD_LOAD, random_symbols(), LEN_W'($urandom_range(31)));
    repeat (4) send_item(bpc_pkg::CMD_CLASSIFY, random_symbols(), LEN_W'($urandom_range(31)));
  endtask

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    cmd_i          = bpc_pkg::CMD_LOAD;
    symbols_i      = '0;
    symbol_count_i = '0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_load_and_exact_match();
    test_thresholds();
    test_random_traffic();
    test_table_full();

    drain_results();
    repeat (20) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      $error("%0d results never arrived", awaited_results.size());
      errors++;
    end
    if (errors == 0)
      $display("** barcode_prefix_classifier_unit: PASSED **");
    else
      $display("** barcode_prefix_classifier_unit: FAILED **");
    $finish;
  end

endmodule
